// File: rtl/lfir_pkg.sv
package lfir_pkg;

  localparam int TAPS_DEF           = 7169;
  localparam int COEF_FRAC_BITS_DEF = 15;
  localparam int VALUE_W            = 16;
  localparam int INDEX_W            = 13;
  localparam int SAMPLE_MAX         = 32767;
  localparam int SAMPLE_MIN         = -32768;

  localparam logic CMD_LOAD_COEF = 1'b0;
  localparam logic CMD_SAMPLE    = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_ROUND,
    S_DONE
  } lfir_state_t;

  typedef struct packed {
    logic load_coef;
    logic store_prime;
    logic start;
    logic issue;
    logic round;
    logic finish;
  } lfir_cmd_t;

  typedef struct packed {
    logic primed;
    logic last_tap;
    logic pipe_busy;
    logic out_free;
  } lfir_sts_t;

endpackage

// File: rtl/lfir_ctrl.sv
module lfir_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              command,
  input  lfir_pkg::lfir_sts_t sts,
  output lfir_pkg::lfir_cmd_t cmd,
  output logic              in_stall
);
  import lfir_pkg::*;

  lfir_state_t state, state_next;
  logic        accept;

  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && command == CMD_SAMPLE && sts.primed) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (sts.last_tap) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.load_coef   = accept && command == CMD_LOAD_COEF;
        cmd.store_prime = accept && command == CMD_SAMPLE && !sts.primed;
        cmd.start       = accept && command == CMD_SAMPLE && sts.primed;
      end
      S_RUN: begin
        cmd.issue = 1'b1;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
      end
      S_DONE: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_start_primed: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> sts.primed)
    else $error("mac pass started before history filled");

  a_run_to_drain: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && sts.last_tap) |=> (state == S_DRAIN))
    else $error("tap sweep did not end after last tap");

endmodule

// File: rtl/lfir_datapath.sv
module lfir_datapath #(
  parameter int TAPS           = lfir_pkg::TAPS_DEF,
  parameter int COEF_FRAC_BITS = lfir_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lfir_pkg::lfir_cmd_t                 cmd,
  output lfir_pkg::lfir_sts_t                 sts,
  input  logic [lfir_pkg::INDEX_W-1:0]        coef_index,
  input  logic signed [lfir_pkg::VALUE_W-1:0] value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lfir_pkg::VALUE_W-1:0] filtered,
  output logic                                saturated
);
  import lfir_pkg::*;

  localparam int HIST  = TAPS - 1;
  localparam int CAW   = $clog2(TAPS);
  localparam int HAW   = (HIST > 1) ? $clog2(HIST) : 1;
  localparam int ACC_W = 2 * VALUE_W + CAW;
  localparam int QW    = ACC_W - COEF_FRAC_BITS;

  localparam logic signed [QW-1:0]    Q_MAX = QW'(SAMPLE_MAX);
  localparam logic signed [QW-1:0]    Q_MIN = QW'(SAMPLE_MIN);
  localparam logic signed [ACC_W-1:0] BIAS  = ACC_W'((64'd1 << COEF_FRAC_BITS) - 64'd1);

  logic signed [VALUE_W-1:0] coef_mem [TAPS];
  logic signed [VALUE_W-1:0] hist_mem [HIST];

  logic [HAW-1:0]            wp;
  logic [CAW-1:0]            seen;
  logic [CAW-1:0]            k;
  logic [HAW-1:0]            rp;
  logic [HAW-1:0]            rp_dec;
  logic signed [VALUE_W-1:0] sample;
  logic signed [VALUE_W-1:0] coef_rd;
  logic signed [VALUE_W-1:0] hist_rd;
  logic                      v1, first1;
  logic                      v2, first2;
  logic signed [2*VALUE_W-1:0] prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_biased;
  logic signed [QW-1:0]      q;
  logic signed [VALUE_W-1:0] x_op;
  logic                      coef_we;
  logic                      hist_we;
  logic [HAW-1:0]            wp_inc;

  assign rp_dec  = (rp == '0) ? HAW'(HIST - 1) : rp - 1'b1;
  assign wp_inc  = (wp == HAW'(HIST - 1)) ? '0 : wp + 1'b1;
  assign coef_we = cmd.load_coef && ({1'b0, coef_index} < (INDEX_W + 1)'(TAPS));
  assign hist_we = cmd.store_prime || cmd.finish;

  assign sts.primed    = (seen == CAW'(HIST));
  assign sts.last_tap  = (k == CAW'(TAPS - 1));
  assign sts.pipe_busy = v1 || v2;
  assign sts.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_index[CAW-1:0]] <= value;
    end
    if (cmd.issue) begin
      coef_rd <= coef_mem[k];
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[wp] <= cmd.finish ? sample : value;
    end
    if (cmd.issue) begin
      hist_rd <= hist_mem[rp_dec];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      seen <= '0;
    end else begin
      if (hist_we) begin
        wp <= wp_inc;
      end
      if (cmd.store_prime) begin
        seen <= seen + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sample <= value;
      k      <= '0;
      rp     <= wp;
    end else if (cmd.issue) begin
      k <= k + 1'b1;
      if (k != '0) begin
        rp <= rp_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  assign x_op = first1 ? sample : hist_rd;

  always_ff @(posedge clk) begin
    first1 <= cmd.issue && (k == '0);
    first2 <= first1;
    if (v1) begin
      prod <= coef_rd * x_op;
    end
    if (v2) begin
      acc <= first2 ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  assign acc_biased = acc[ACC_W-1] ? acc + BIAS : acc;

  always_ff @(posedge clk) begin
    if (cmd.round) begin
      q <= QW'(acc_biased >>> COEF_FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (q > Q_MAX) begin
        filtered  <= VALUE_W'(SAMPLE_MAX);
        saturated <= 1'b1;
      end else if (q < Q_MIN) begin
        filtered  <= VALUE_W'(SAMPLE_MIN);
        saturated <= 1'b1;
      end else begin
        filtered  <= q[VALUE_W-1:0];
        saturated <= 1'b0;
      end
    end
  end

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || !out_stall))
    else $error("result beat overwrote a waiting result");

  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.store_prime |=> (seen <= CAW'(HIST)))
    else $error("priming count overran history depth");

endmodule

// File: rtl/long_fir_fast_convolution_top.sv
// Direct-form long FIR on one shared 16x16 MAC fed from coefficient and history RAMs.
// Coefficient load and priming sample: next beat accepted the following cycle.
// Filtering sample: accept, a one-tap-per-cycle sweep through the RAM read ports,
// MAC drain, rounding and the result beat when output is free; one sample at a time.
// Sync reset clears control, write pointer and fill count; RAM contents stay unknown.
module long_fir_fast_convolution_top #(
  parameter int TAPS           = lfir_pkg::TAPS_DEF,
  parameter int COEF_FRAC_BITS = lfir_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                command,
  input  logic [lfir_pkg::INDEX_W-1:0]        coef_index,
  input  logic signed [lfir_pkg::VALUE_W-1:0] value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lfir_pkg::VALUE_W-1:0] filtered,
  output logic                                saturated
);
  import lfir_pkg::*;

  lfir_cmd_t cmd;
  lfir_sts_t sts;

  lfir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  lfir_datapath #(
    .TAPS           (TAPS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .coef_index (coef_index),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .filtered   (filtered),
    .saturated  (saturated)
  );

endmodule
